### sv/btb_pkg.sv
package btb_pkg;

    localparam int DEF_ENTRIES = 32;
    localparam int ADDR_W      = 32;
    localparam int WORD_W      = ADDR_W - 2;
    localparam int S_DATA_W    = 72;
    localparam int M_DATA_W    = 40;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam logic [1:0] CNT_SNT = 2'd0;
    localparam logic [1:0] CNT_WNT = 2'd1;
    localparam logic [1:0] CNT_WT  = 2'd2;
    localparam logic [1:0] CNT_ST  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [1:0]        cnt;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] target;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [1:0] next_cnt(input logic [1:0] cnt, input logic taken);
        logic [1:0] res;
        if (taken)
        begin
            res = (cnt == CNT_SNT) ? CNT_WNT : CNT_ST;
        end
        else
        begin
            res = (cnt == CNT_ST) ? CNT_WT : CNT_SNT;
        end
        return res;
    endfunction

endpackage

### sv/btb_ram.sv
module btb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/branch_target_buffer_two_bit.sv
// channel  dir  handshake          tdata / tuser
// s_*      in   s_tvalid/s_tready  inst_addr, target_addr, taken / kind
// m_*      out  m_tvalid/m_tready  predict_taken, predict_target / hit
//
// One word at a time: accept, table read, then write-back (update) or result
// load (predict). With ENTRIES not a power of two, a divide state before the
// read reduces the reciprocal-multiply quotient to the index.
// After reset a clear pass writes all ENTRIES table rows, one per cycle,
// before the first word is taken. A stalled result waits in the output
// register while the next word is accepted; a predict then holds until it frees.
module branch_target_buffer_two_bit #(
    parameter int ENTRIES = btb_pkg::DEF_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [btb_pkg::S_DATA_W-1:0]  s_tdata,   // inst_addr, target_addr, taken, zero pad
    input  logic                          s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [btb_pkg::M_DATA_W-1:0]  m_tdata,   // predict_taken, predict_target, zero pad
    output logic                          m_tuser    // hit
);

    import btb_pkg::*;

    localparam int              IDXW     = $clog2(ENTRIES);
    localparam bit              IS_POW2  = ((ENTRIES & (ENTRIES - 1)) == 0);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
    localparam logic [IDXW-1:0] ENT_LOW  = IDXW'(ENTRIES);
    localparam int              PROD_W   = WORD_W + 32;
    localparam int              Q_LSB    = WORD_W + IDXW;
    // ceil(2^(WORD_W+IDXW) / ENTRIES): exact quotient for any WORD_W-bit word
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << Q_LSB) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
    localparam logic [31:0]     RECIP    = 32'(RECIP_FULL);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIV   = 4'b0100,
        S_LOOK  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDXW-1:0]   clr_reg, clr_next;
    logic [IDXW-1:0]   quo_reg, quo_next;
    logic [IDXW-1:0]   idx_reg, idx_next;
    logic              kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] tgt_reg, tgt_next;
    logic              taken_reg, taken_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg, m_hit_next;
    logic              m_taken_reg, m_taken_next;
    logic [ADDR_W-1:0] m_target_reg, m_target_next;

    logic              ram_we, ram_re;
    logic [IDXW-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic              in_acc, out_free;
    logic [WORD_W-1:0] word;
    logic [PROD_W-1:0] recip_prod;
    logic [2*IDXW-1:0] quo_mul;
    logic [IDXW-1:0]   idx_mod;
    entry_t            rd_entry, upd_entry;
    logic              lk_hit, lk_taken;

    btb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign word       = addr_reg[ADDR_W-1:2];
    assign recip_prod = PROD_W'(s_tdata[ADDR_W-1:2]) * PROD_W'(RECIP);
    assign quo_mul    = (2*IDXW)'(quo_reg) * (2*IDXW)'(ENT_LOW);
    assign idx_mod    = word[IDXW-1:0] - quo_mul[IDXW-1:0];

    assign rd_entry = entry_t'(ram_rdata);
    assign lk_hit   = rd_entry.valid && (rd_entry.tag == addr_reg);
    assign lk_taken = rd_entry.cnt[1];

    always_comb
    begin
        upd_entry        = '0;
        upd_entry.valid  = 1'b1;
        upd_entry.cnt    = next_cnt(rd_entry.cnt, taken_reg);
        upd_entry.tag    = addr_reg;
        upd_entry.target = tgt_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        quo_next      = quo_reg;
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        tgt_next      = tgt_reg;
        taken_next    = taken_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_hit_next    = m_hit_reg;
        m_taken_next  = m_taken_reg;
        m_target_next = m_target_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ENTRY_W'(upd_entry);
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next  = s_tuser;
                    addr_next  = s_tdata[31:0];
                    tgt_next   = s_tdata[63:32];
                    taken_next = s_tdata[64];
                    if (IS_POW2)
                    begin
                        idx_next   = s_tdata[IDXW+1:2];
                        ram_re     = 1'b1;
                        ram_raddr  = s_tdata[IDXW+1:2];
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        quo_next   = recip_prod[Q_LSB +: IDXW];
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                idx_next   = idx_mod;
                ram_re     = 1'b1;
                ram_raddr  = idx_mod;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (kind_reg == KIND_UPDATE)
                begin
                    ram_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_hit_next    = lk_hit;
                    m_taken_next  = lk_hit && lk_taken;
                    m_target_next = !lk_hit ? '0
                                  : (lk_taken ? rd_entry.target : addr_reg + 32'd4);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        idx_reg      <= idx_next;
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        tgt_reg      <= tgt_next;
        taken_reg    <= taken_next;
        m_hit_reg    <= m_hit_next;
        m_taken_reg  <= m_taken_next;
        m_target_reg <= m_target_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {7'b0, m_target_reg, m_taken_reg};

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != S_IDLE)
        else $error("word accepted but block did not leave idle");

    a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !m_tvalid)
        else $error("result presented during clear pass");

    a_wb_update_only: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && state_reg == S_LOOK |-> kind_reg == KIND_UPDATE)
        else $error("table write-back for a predict word");

    a_out_from_predict: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_LOOK && kind_reg == KIND_PREDICT))
        else $error("result loaded outside a predict lookup");

endmodule

### tb/sv/btb_stream_checker.sv
`timescale 1ns / 1ps

module btb_stream_checker #(
    parameter int ENTRIES = btb_pkg::DEF_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [btb_pkg::S_DATA_W-1:0]  s_tdata,   // inst_addr, target_addr, taken, zero pad
    input  logic                          s_tuser,   // kind
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [btb_pkg::M_DATA_W-1:0]  m_tdata,   // predict_taken, predict_target, zero pad
    input  logic                          m_tuser,   // hit
    output int                            fails,
    output int                            pending
);

    import btb_pkg::*;

    typedef struct packed {
        logic              hit;
        logic              taken;
        logic [ADDR_W-1:0] target;
    } lookup_t;

    logic              ent_valid  [ENTRIES];
    logic [1:0]        ent_cnt    [ENTRIES];
    logic [ADDR_W-1:0] ent_tag    [ENTRIES];
    logic [ADDR_W-1:0] ent_target [ENTRIES];

    lookup_t           lookup_q [$];
    lookup_t           want;
    logic [ADDR_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_target;
    logic              w_taken;
    int unsigned       w_slot;
    int                err_cnt;

    function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr,
                                               input int unsigned slot);
        lookup_t res;
        res = '0;
        if (ent_valid[slot] && ent_tag[slot] == addr)
        begin
            res.hit    = 1'b1;
            res.taken  = (ent_cnt[slot] == CNT_WT) || (ent_cnt[slot] == CNT_ST);
            res.target = res.taken ? ent_target[slot] : addr + 32'd4;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                ent_valid[i]  = 1'b0;
                ent_cnt[i]    = CNT_SNT;
                ent_tag[i]    = '0;
                ent_target[i] = '0;
            end
            lookup_q.delete();
            err_cnt = 0;
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (lookup_q.size() == 0)
                begin
                    $error("result word with no lookup pending: hit=%0b data=%h",
                           m_tuser, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (m_tuser !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, m_tuser);
                        err_cnt++;
                    end
                    if (m_tdata[0] !== want.taken)
                    begin
                        $error("predict_taken: expected %0b, got %0b", want.taken, m_tdata[0]);
                        err_cnt++;
                    end
                    if (m_tdata[32:1] !== want.target)
                    begin
                        $error("predict_target: expected %h, got %h", want.target,
                               m_tdata[32:1]);
                        err_cnt++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                w_addr   = s_tdata[31:0];
                w_target = s_tdata[63:32];
                w_taken  = s_tdata[64];
                w_slot   = (w_addr >> 2) % ENTRIES;
                if (s_tuser == KIND_UPDATE)
                begin
                    ent_valid[w_slot]  = 1'b1;
                    ent_tag[w_slot]    = w_addr;
                    ent_target[w_slot] = w_target;
                    if (w_taken)
                        ent_cnt[w_slot] = (ent_cnt[w_slot] == CNT_SNT) ? CNT_WNT : CNT_ST;
                    else
                        ent_cnt[w_slot] = (ent_cnt[w_slot] == CNT_ST) ? CNT_WT : CNT_SNT;
                end
                else
                begin
                    lookup_q.push_back(predict_lookup(w_addr, w_slot));
                end
            end

            fails   <= err_cnt;
            pending <= lookup_q.size();
        end
    end

endmodule

### tb/sv/branch_target_buffer_two_bit_tb.sv
`timescale 1ns / 1ps

module branch_target_buffer_two_bit_tb;

    import btb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_LEN    = 300;
    localparam int POOL        = 24;
    localparam int PHASE_WORDS = 384;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;   // inst_addr, target_addr, taken, zero pad
    logic                 s_tuser  = 1'b0; // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;         // predict_taken, predict_target, zero pad
    logic                 m_tuser;         // hit

    int fails;
    int pending;
    int cycles      = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs   = 0;
    int hold_done   = 0;
    int hold_left   = 0;

    logic [ADDR_W-1:0] addr_pool [POOL];

    branch_target_buffer_two_bit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    btb_stream_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .fails    (fails),
        .pending  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_reqs != hold_done)
        begin
            hold_done = hold_done + 1;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [ADDR_W-1:0] target, input logic taken);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, taken, target, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_lookups();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_word();
        logic [ADDR_W-1:0] addr;
        if ($urandom_range(0, 99) < 85)
            addr = addr_pool[$urandom_range(0, POOL - 1)];
        else
            addr = $urandom;
        send_word(1'($urandom_range(0, 1)), addr, $urandom, $urandom_range(0, 99) < 65);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, address extremes
        send_word(KIND_PREDICT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        // walk one entry through every counter state; not-taken target wraps
        send_word(KIND_UPDATE,  32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        send_word(KIND_UPDATE,  32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        send_word(KIND_UPDATE,  32'hFFFF_FFFC, 32'h8000_0001, 1'b0);
        send_word(KIND_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        send_word(KIND_UPDATE,  32'hFFFF_FFFC, 32'h8000_0001, 1'b1);
        send_word(KIND_UPDATE,  32'hFFFF_FFFC, 32'h8000_0001, 1'b0);
        send_word(KIND_UPDATE,  32'hFFFF_FFFC, 32'h8000_0001, 1'b0);
        send_word(KIND_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        // same index, other tag; same word, other byte offset
        send_word(KIND_PREDICT, 32'hFFFF_FF7C, 32'h0000_0000, 1'b0);
        send_word(KIND_PREDICT, 32'hFFFF_FFFD, 32'h0000_0000, 1'b0);
        send_word(KIND_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b0);
        send_word(KIND_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // weak not taken back to strong not taken
        send_word(KIND_UPDATE,  32'h0000_007C, 32'hAAAA_AAAA, 1'b1);
        send_word(KIND_PREDICT, 32'h0000_007C, 32'h0000_0000, 1'b0);
        send_word(KIND_UPDATE,  32'h0000_007C, 32'h5555_5555, 1'b0);
        send_word(KIND_PREDICT, 32'h0000_007C, 32'h0000_0000, 1'b0);
        // retag keeps the counter of the slot
        send_word(KIND_UPDATE,  32'h0000_107C, 32'h1234_5678, 1'b1);
        send_word(KIND_UPDATE,  32'h0000_207C, 32'h8765_4321, 1'b1);
        send_word(KIND_PREDICT, 32'h0000_207C, 32'h0000_0000, 1'b0);
        send_word(KIND_PREDICT, 32'h0000_107C, 32'h0000_0000, 1'b0);
        drain_lookups();

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 61 : 0;
            rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 10 : 0;
            // aliasing pool: few index values, random tags
            for (int i = 0; i < POOL; i++)
            begin
                addr_pool[i] = $urandom;
                addr_pool[i][6:2] = 5'($urandom_range(0, 7));
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (ph == 0 && i == 100)
                    hold_reqs = hold_reqs + 1;
                if (ph == 1 && i == 200)
                    drain_lookups();
                random_word();
            end
            drain_lookups();
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### branch_target_buffer_two_bit.f
sv/btb_pkg.sv
sv/btb_ram.sv
sv/branch_target_buffer_two_bit.sv
tb/sv/btb_stream_checker.sv
tb/sv/branch_target_buffer_two_bit_tb.sv
